// ----- rtl/bcpc_pkg.sv -----
// shared types, register map and reset values for the breaker coil pulse controller
package bcpc_pkg;

  // input item fields
  typedef struct packed {
    logic [3:0] elapsed;
    logic       close_irq;
    logic       open_irq;
    logic       overcurrent_irq;
    logic       close_cmd_level;
    logic       open_cmd_level;
    logic       local_level;
    logic       charged_level;
  } in_item_t;

  // result item fields
  typedef struct packed {
    logic close_coil;
    logic open_coil;
    logic fault_led_on;
    logic run_led_level;
    logic charged_status;
    logic local_status;
  } out_item_t;

  // configuration register set
  typedef struct packed {
    logic [15:0] close_pulse_ticks;
    logic [15:0] open_pulse_ticks;
    logic [15:0] command_debounce_ticks;
    logic [7:0]  status_debounce_ticks;
    logic [15:0] fault_led_ticks;
    logic [15:0] run_led_half_period;
    logic [15:0] slow_tick_period;
  } cfg_t;

  // register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_CLOSE_PULSE  = 3'd0,
    REG_OPEN_PULSE   = 3'd1,
    REG_CMD_DEBOUNCE = 3'd2,
    REG_STS_DEBOUNCE = 3'd3,
    REG_FAULT_LED    = 3'd4,
    REG_RUN_HALF     = 3'd5,
    REG_SLOW_PERIOD  = 3'd6
  } reg_idx_t;

  localparam int PADDR_W = 5;

  // register reset values
  localparam logic [15:0] CLOSE_PULSE_RST  = 16'd500;
  localparam logic [15:0] OPEN_PULSE_RST   = 16'd500;
  localparam logic [15:0] CMD_DEBOUNCE_RST = 16'd100;
  localparam logic [7:0]  STS_DEBOUNCE_RST = 8'd3;
  localparam logic [15:0] FAULT_LED_RST    = 16'd300;
  localparam logic [15:0] RUN_HALF_RST     = 16'd50;
  localparam logic [15:0] SLOW_PERIOD_RST  = 16'd100;

  // status input slots
  localparam int STS_LOCAL   = 0;
  localparam int STS_CHARGED = 1;

endpackage

// ----- rtl/bcpc_core.sv -----
// per-tick controller state and the result it produces for each accepted item
module bcpc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  bcpc_pkg::in_item_t item,
  input  bcpc_pkg::cfg_t     cfg,
  output bcpc_pkg::out_item_t result
);

  // controller state
  logic        close_pending, open_pending, close_armed, open_armed;
  logic [15:0] close_low_count, open_low_count;
  logic        overcurrent_delay;
  logic [16:0] close_timer, open_timer;
  logic [7:0]  status_counts [2];
  logic [1:0]  status_states;
  logic [15:0] slow_tick_count, fault_count;
  logic [16:0] run_count;
  logic        run_led_reg;

  // next state
  logic        close_pending_next, open_pending_next, close_armed_next, open_armed_next;
  logic [15:0] close_low_count_next, open_low_count_next;
  logic        overcurrent_delay_next;
  logic [16:0] close_timer_next, open_timer_next;
  logic [7:0]  status_counts_next [2];
  logic [1:0]  status_states_next;
  logic [15:0] slow_tick_count_next, fault_count_next;
  logic [16:0] run_count_next;
  logic        run_led_reg_next;

  // one tick of the controller in model order
  always_comb begin
    logic [16:0] slow_sum;
    logic [1:0]  levels;
    close_pending_next     = close_pending | item.close_irq;
    open_pending_next      = open_pending | item.open_irq;
    overcurrent_delay_next = overcurrent_delay | item.overcurrent_irq;
    close_armed_next       = close_armed;
    open_armed_next        = open_armed;
    close_low_count_next   = close_low_count;
    open_low_count_next    = open_low_count;
    close_timer_next       = close_timer;
    open_timer_next        = open_timer;
    status_counts_next     = status_counts;
    status_states_next     = status_states;
    slow_tick_count_next   = slow_tick_count;
    fault_count_next       = fault_count;
    run_count_next         = run_count;
    run_led_reg_next       = run_led_reg;
    levels                 = {item.charged_level, item.local_level};
    slow_sum               = '0;

    // close command, needs a charged spring to start the pulse
    if (close_pending_next && close_armed_next) begin
      if (status_states[bcpc_pkg::STS_CHARGED]) begin
        close_timer_next = 17'd1;
      end
      close_pending_next = 1'b0;
      close_armed_next   = 1'b0;
    end
    // open command wins over any close pulse
    if (open_pending_next && open_armed_next) begin
      close_timer_next  = '0;
      open_timer_next   = 17'd1;
      open_pending_next = 1'b0;
      open_armed_next   = 1'b0;
    end

    if (item.elapsed != 4'd0) begin
      // command level debounce, saturating low count
      if (!item.close_cmd_level) begin
        if (close_low_count_next != 16'hFFFF) begin
          close_low_count_next = close_low_count_next + 16'd1;
        end
      end else begin
        close_low_count_next = '0;
      end
      if (close_low_count_next == cfg.command_debounce_ticks) begin
        close_armed_next = 1'b1;
      end
      if (!item.open_cmd_level) begin
        if (open_low_count_next != 16'hFFFF) begin
          open_low_count_next = open_low_count_next + 16'd1;
        end
      end else begin
        open_low_count_next = '0;
      end
      if (open_low_count_next == cfg.command_debounce_ticks) begin
        open_armed_next = 1'b1;
      end

      // overcurrent abort, taken on the first item with a nonzero elapsed time
      if (overcurrent_delay_next) begin
        overcurrent_delay_next = 1'b0;
        close_timer_next       = '0;
        open_timer_next        = '0;
        fault_count_next       = cfg.fault_led_ticks;
      end

      // running pulses
      if (close_timer_next != '0) begin
        close_timer_next = close_timer_next + 17'(item.elapsed);
        if (close_timer_next > {1'b0, cfg.close_pulse_ticks}) begin
          close_timer_next = '0;
        end
      end
      if (open_timer_next != '0) begin
        open_timer_next = open_timer_next + 17'(item.elapsed);
        if (open_timer_next > {1'b0, cfg.open_pulse_ticks}) begin
          open_timer_next = '0;
        end
      end

      // slow tick prescaler, saturating
      slow_sum = {1'b0, slow_tick_count} + 17'(item.elapsed);
      slow_tick_count_next = slow_sum[16] ? 16'hFFFF : slow_sum[15:0];
      if (slow_tick_count_next >= cfg.slow_tick_period) begin
        slow_tick_count_next = '0;

        // status debounce
        for (int i = 0; i < 2; i++) begin
          if (levels[i] != status_states[i]) begin
            if (status_counts[i] != 8'hFF) begin
              status_counts_next[i] = status_counts[i] + 8'd1;
            end
            if (status_counts_next[i] >= cfg.status_debounce_ticks) begin
              status_states_next[i] = levels[i];
              status_counts_next[i] = '0;
            end
          end else begin
            status_counts_next[i] = '0;
          end
        end

        // run led blink
        run_count_next = run_count + 17'd1;
        if (run_count_next == {1'b0, cfg.run_led_half_period}) begin
          run_led_reg_next = 1'b0;
        end else if (run_count_next >= {cfg.run_led_half_period, 1'b0}) begin
          run_led_reg_next = 1'b1;
          run_count_next   = '0;
        end

        // fault led hold time
        if (fault_count_next != '0) begin
          fault_count_next = fault_count_next - 16'd1;
        end
      end
    end
  end

  // result of this item
  always_comb begin
    result.close_coil     = close_timer_next != '0;
    result.open_coil      = open_timer_next != '0;
    result.fault_led_on   = fault_count_next != '0;
    result.run_led_level  = run_led_reg_next;
    result.charged_status = status_states_next[bcpc_pkg::STS_CHARGED];
    result.local_status   = status_states_next[bcpc_pkg::STS_LOCAL];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      close_pending     <= 1'b0;
      open_pending      <= 1'b0;
      close_armed       <= 1'b0;
      open_armed        <= 1'b0;
      close_low_count   <= '0;
      open_low_count    <= '0;
      overcurrent_delay <= 1'b0;
      close_timer       <= '0;
      open_timer        <= '0;
      status_counts[0]  <= '0;
      status_counts[1]  <= '0;
      status_states     <= '0;
      slow_tick_count   <= '0;
      fault_count       <= '0;
      run_count         <= '0;
      run_led_reg       <= 1'b1;
    end else if (accept) begin
      close_pending     <= close_pending_next;
      open_pending      <= open_pending_next;
      close_armed       <= close_armed_next;
      open_armed        <= open_armed_next;
      close_low_count   <= close_low_count_next;
      open_low_count    <= open_low_count_next;
      overcurrent_delay <= overcurrent_delay_next;
      close_timer       <= close_timer_next;
      open_timer        <= open_timer_next;
      status_counts     <= status_counts_next;
      status_states     <= status_states_next;
      slow_tick_count   <= slow_tick_count_next;
      fault_count       <= fault_count_next;
      run_count         <= run_count_next;
      run_led_reg       <= run_led_reg_next;
    end
  end

endmodule

// ----- rtl/breaker_coil_pulse_controller.sv -----
// top level: register port, controller core and result register
// a result is registered when its input transaction is accepted and shows in the cycle after
// throughput: one item per cycle; the single result register stalls the input
//   only while it holds a result that the output side does not take
// reset: synchronous, active high; clears all controller state (run led to 1),
//   loads the configuration registers with their default values
module breaker_coil_pulse_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bcpc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bcpc_pkg::out_item_t                out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bcpc_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  bcpc_pkg::cfg_t      cfg;
  bcpc_pkg::out_item_t result;
  bcpc_pkg::reg_idx_t  reg_idx;
  logic                accept;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = bcpc_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.close_pulse_ticks      <= bcpc_pkg::CLOSE_PULSE_RST;
      cfg.open_pulse_ticks       <= bcpc_pkg::OPEN_PULSE_RST;
      cfg.command_debounce_ticks <= bcpc_pkg::CMD_DEBOUNCE_RST;
      cfg.status_debounce_ticks  <= bcpc_pkg::STS_DEBOUNCE_RST;
      cfg.fault_led_ticks        <= bcpc_pkg::FAULT_LED_RST;
      cfg.run_led_half_period    <= bcpc_pkg::RUN_HALF_RST;
      cfg.slow_tick_period       <= bcpc_pkg::SLOW_PERIOD_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        bcpc_pkg::REG_CLOSE_PULSE:  cfg.close_pulse_ticks      <= pwdata[15:0];
        bcpc_pkg::REG_OPEN_PULSE:   cfg.open_pulse_ticks       <= pwdata[15:0];
        bcpc_pkg::REG_CMD_DEBOUNCE: cfg.command_debounce_ticks <= pwdata[15:0];
        bcpc_pkg::REG_STS_DEBOUNCE: cfg.status_debounce_ticks  <= pwdata[7:0];
        bcpc_pkg::REG_FAULT_LED:    cfg.fault_led_ticks        <= pwdata[15:0];
        bcpc_pkg::REG_RUN_HALF:     cfg.run_led_half_period    <= pwdata[15:0];
        bcpc_pkg::REG_SLOW_PERIOD:  cfg.slow_tick_period       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      bcpc_pkg::REG_CLOSE_PULSE:  prdata = {16'd0, cfg.close_pulse_ticks};
      bcpc_pkg::REG_OPEN_PULSE:   prdata = {16'd0, cfg.open_pulse_ticks};
      bcpc_pkg::REG_CMD_DEBOUNCE: prdata = {16'd0, cfg.command_debounce_ticks};
      bcpc_pkg::REG_STS_DEBOUNCE: prdata = {24'd0, cfg.status_debounce_ticks};
      bcpc_pkg::REG_FAULT_LED:    prdata = {16'd0, cfg.fault_led_ticks};
      bcpc_pkg::REG_RUN_HALF:     prdata = {16'd0, cfg.run_led_half_period};
      bcpc_pkg::REG_SLOW_PERIOD:  prdata = {16'd0, cfg.slow_tick_period};
      default:                    prdata = '0;
    endcase
  end

  bcpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

// ----- rtl/bcpc_checker.sv -----
// port-level checks for the breaker coil pulse controller and their bind
module bcpc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bcpc_pkg::out_item_t out_data
);

  // no result pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // every accepted transaction shows a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction gave no result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind breaker_coil_pulse_controller bcpc_checker u_bcpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
